// ===== hdl/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants for the compass bearing core
// Request and result payloads, the CORDIC cell vector and the arctangent
// table in binary-angle units (2^32 units per turn).
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int XY_W    = COORD_W + 4;   // room for CORDIC gain and sqrt(2)
    localparam int ANGLE_W = 32;
    localparam int Z_W     = ANGLE_W + 2;
    localparam int DEG_W   = 10;
    localparam int MAG_W   = 9;
    localparam int MUL_W   = ANGLE_W + MAG_W;
    localparam int MAX_STAGES = 32;

    localparam logic [MAG_W-1:0] DEG_PER_TURN = 9'd360;

    localparam logic signed [Z_W-1:0] Z_HALF    = 34'sh0_8000_0000;
    localparam logic signed [Z_W-1:0] Z_QUARTER = 34'sh0_4000_0000;
    localparam logic signed [Z_W-1:0] Z_FULL    = 34'sh1_0000_0000;

    localparam logic [ANGLE_W-1:0] ATAN_BAM [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] observer_x;
        logic signed [COORD_W-1:0] observer_y;
        logic signed [COORD_W-1:0] object_x;
        logic signed [COORD_W-1:0] object_y;
    } cbd_req_t;

    typedef struct packed {
        logic signed [DEG_W-1:0] bearing_deg;
        logic                    coincident;
    } cbd_rsp_t;

    typedef struct packed {
        logic                   valid;
        logic                   coincident;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cbd_vec_t;

endpackage

// ===== hdl/cbd_front.sv =====
// ----------------------------------------------------------------------------
// cbd_front: coordinate differences and initial rotation
// Stage one forms the east and north differences; stage two folds the
// vector into the right half-plane and seeds the angle.
// ----------------------------------------------------------------------------
module cbd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              req_valid,
    input  cbd_pkg::cbd_req_t req_data,
    output cbd_pkg::cbd_vec_t vec
);
    import cbd_pkg::*;

    logic                     valid_a_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic signed [XY_W-1:0]   dx_ext;
    logic signed [XY_W-1:0]   dy_ext;
    cbd_vec_t                 vec_reg;
    cbd_vec_t                 vec_next;

    assign dx_next = DIFF_W'(req_data.object_x) - DIFF_W'(req_data.observer_x);
    assign dy_next = DIFF_W'(req_data.object_y) - DIFF_W'(req_data.observer_y);
    assign dx_ext  = XY_W'(dx_reg);
    assign dy_ext  = XY_W'(dy_reg);

    always_comb
    begin
        vec_next.valid      = valid_a_reg;
        vec_next.coincident = (dx_reg == '0) && (dy_reg == '0);
        vec_next.x          = dy_ext;
        vec_next.y          = dx_ext;
        vec_next.z          = '0;
        if (dy_reg < 0)
        begin
            // rotate by half a turn
            vec_next.x = -dy_ext;
            vec_next.y = -dx_ext;
            vec_next.z = Z_HALF;
        end
        else if (dy_reg == '0)
        begin
            // on the east-west axis: land on +x exactly
            vec_next.y = '0;
            if (dx_reg > 0)
            begin
                vec_next.x = dx_ext;
                vec_next.z = Z_QUARTER;
            end
            else
            begin
                vec_next.x = -dx_ext;
                vec_next.z = -Z_QUARTER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            vec_reg     <= '0;
        end
        else if (advance)
        begin
            valid_a_reg <= req_valid;
            vec_reg     <= vec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    assign vec = vec_reg;

endmodule

// ===== hdl/cbd_cell.sv =====
// ----------------------------------------------------------------------------
// cbd_cell: one CORDIC vectoring cell
// Rotates toward y = 0 by atan(2^-STAGE) and hands the vector on; a vector
// already on the axis passes unchanged.
// ----------------------------------------------------------------------------
module cbd_cell #(
    parameter int STAGE = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  cbd_pkg::cbd_vec_t vec_in,
    output cbd_pkg::cbd_vec_t vec_out
);
    import cbd_pkg::*;

    localparam logic signed [Z_W-1:0] ANGLE = Z_W'(ATAN_BAM[STAGE]);

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    cbd_vec_t               vec_reg;
    cbd_vec_t               vec_next;

    assign xs = vec_in.x >>> STAGE;
    assign ys = vec_in.y >>> STAGE;

    always_comb
    begin
        vec_next = vec_in;
        if (vec_in.y > 0)
        begin
            vec_next.x = vec_in.x + ys;
            vec_next.y = vec_in.y - xs;
            vec_next.z = vec_in.z + ANGLE;
        end
        else if (vec_in.y < 0)
        begin
            vec_next.x = vec_in.x - ys;
            vec_next.y = vec_in.y + xs;
            vec_next.z = vec_in.z - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vec_reg <= '0;
        else if (advance)
            vec_reg <= vec_next;
    end

    assign vec_out = vec_reg;

endmodule

// ===== hdl/cbd_back.sv =====
// ----------------------------------------------------------------------------
// cbd_back: angle to degrees and result register
// Wraps the angle, scales it by 360 per turn and applies the range mode.
// ----------------------------------------------------------------------------
module cbd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              mode,
    input  cbd_pkg::cbd_vec_t vec,
    output logic              rsp_valid,
    output cbd_pkg::cbd_rsp_t rsp_data
);
    import cbd_pkg::*;

    logic signed [Z_W-1:0]   zw;
    logic                    neg_next;
    logic [ANGLE_W-1:0]      mag_next;
    logic                    valid_c_reg;
    logic                    coin_c_reg;
    logic                    neg_c_reg;
    logic [ANGLE_W-1:0]      mag_c_reg;
    logic [MUL_W-1:0]        prod;
    logic                    valid_d_reg;
    logic                    coin_d_reg;
    logic                    neg_d_reg;
    logic [MAG_W-1:0]        deg_d_reg;
    logic signed [DEG_W-1:0] deg_ext;
    logic                    rsp_valid_reg;
    cbd_rsp_t                rsp_data_reg;
    cbd_rsp_t                rsp_data_next;

    always_comb
    begin
        zw       = (vec.z > Z_HALF) ? (vec.z - Z_FULL) : vec.z;
        neg_next = mode && (zw < 0);
        // mode 0 reads the low word as an unsigned turn fraction
        mag_next = neg_next ? ANGLE_W'(-zw) : zw[ANGLE_W-1:0];
    end

    assign prod    = MUL_W'(mag_c_reg) * MUL_W'(DEG_PER_TURN);
    assign deg_ext = DEG_W'(deg_d_reg);

    always_comb
    begin
        rsp_data_next.coincident  = coin_d_reg;
        rsp_data_next.bearing_deg = neg_d_reg ? -deg_ext : deg_ext;
        if (coin_d_reg)
            rsp_data_next.bearing_deg = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_c_reg   <= 1'b0;
            valid_d_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_c_reg   <= vec.valid;
            valid_d_reg   <= valid_c_reg;
            rsp_valid_reg <= valid_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            coin_c_reg   <= vec.coincident;
            neg_c_reg    <= neg_next;
            mag_c_reg    <= mag_next;
            coin_d_reg   <= coin_c_reg;
            neg_d_reg    <= neg_c_reg;
            deg_d_reg    <= prod[MUL_W-1:ANGLE_W];
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ===== hdl/compass_bearing_2d_core.sv =====
// ----------------------------------------------------------------------------
// compass_bearing_2d_core: bearing from observer to object in whole degrees
// Path: difference register, fold register, the CORDIC cells, then the angle, degree and result registers.
// Throughput: one request per cycle; the whole pipeline holds while the
// result register is full and stalled.
// Reset: clears all valid flags and sets the range mode to 0..359.
// ----------------------------------------------------------------------------
module compass_bearing_2d_core #(
    parameter int CORDIC_STAGES = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  cbd_pkg::cbd_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cbd_pkg::cbd_rsp_t rsp_data
);
    import cbd_pkg::*;

    logic     mode_reg;
    logic     advance;
    cbd_vec_t chain [CORDIC_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    // advance everything unless a finished result is waiting
    assign advance   = !(rsp_valid && rsp_stall);
    assign req_stall = !advance;

    cbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req_valid (req_valid),
        .req_data  (req_data),
        .vec       (chain[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        cbd_cell #(
            .STAGE (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .vec_in  (chain[i]),
            .vec_out (chain[i+1])
        );
    end

    cbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .mode      (mode_reg),
        .vec       (chain[CORDIC_STAGES]),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

`ifndef SYNTHESIS
    a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.coincident |-> rsp_data.bearing_deg == '0)
        else $error("coincident result with nonzero bearing");

    a_unsigned_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !mode_reg |->
            !rsp_data.bearing_deg[DEG_W-1] && (rsp_data.bearing_deg <= 10'sd359))
        else $error("bearing outside 0..359");

    a_centered_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && mode_reg |->
            (rsp_data.bearing_deg >= -10'sd180) && (rsp_data.bearing_deg <= 10'sd180))
        else $error("bearing outside -180..180");

    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("request taken while result is held");
`endif

endmodule

// ===== tb/compass_bearing_2d_checker.sv =====
// ----------------------------------------------------------------------------
// compass_bearing_2d_checker: bearing predictor and result scoreboard
// Watches the request, result and mode-register ports of the compass bearing
// core. Each accepted request is turned into an expected bearing by a local
// CORDIC model, and each accepted result is compared with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module compass_bearing_2d_checker #(
    parameter int CORDIC_STAGES = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              req_valid,
    input  logic              req_stall,
    input  cbd_pkg::cbd_req_t req_data,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  cbd_pkg::cbd_rsp_t rsp_data,
    output int                mismatches,
    output int                outstanding,
    output int                checked
);
    import cbd_pkg::*;

    localparam longint HALF_TURN    = 64'sh0_8000_0000;
    localparam longint QUARTER_TURN = 64'sh0_4000_0000;
    localparam longint FULL_TURN    = 64'sh1_0000_0000;
    localparam longint DEG_TURN     = 360;

    logic     centered_mode;
    cbd_rsp_t expected_bearings [$];

    function automatic cbd_rsp_t bearing_of(cbd_req_t r, logic centered);
        longint   east;
        longint   north;
        longint   x;
        longint   y;
        longint   z;
        longint   xs;
        longint   ys;
        longint   deg;
        cbd_rsp_t res;
        res   = '0;
        east  = longint'(r.object_x) - longint'(r.observer_x);
        north = longint'(r.object_y) - longint'(r.observer_y);
        if (east == 0 && north == 0)
        begin
            res.coincident = 1'b1;
            return res;
        end
        x = north;
        y = east;
        z = 0;
        // fold the vector into the right half-plane
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        else if (x == 0)
        begin
            if (y > 0)
            begin
                x = y;
                z = QUARTER_TURN;
            end
            else
            begin
                x = -y;
                z = -QUARTER_TURN;
            end
            y = 0;
        end
        for (int i = 0; i < CORDIC_STAGES && i < MAX_STAGES; i++)
        begin
            // hold once the vector lies on the axis
            if (y == 0)
                break;
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_BAM[i]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_BAM[i]);
            end
        end
        if (z > HALF_TURN)
            z = z - FULL_TURN;
        if (centered)
        begin
            if (z < 0)
                deg = -(((-z) * DEG_TURN) >>> 32);
            else
                deg = (z * DEG_TURN) >>> 32;
        end
        else
        begin
            if (z < 0)
                z = z + FULL_TURN;
            deg = (z * DEG_TURN) >>> 32;
        end
        res.bearing_deg = deg[DEG_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cbd_rsp_t want;
        if (!rst_n)
        begin
            centered_mode <= 1'b0;
            mismatches    <= 0;
            outstanding   <= 0;
            checked       <= 0;
            expected_bearings.delete();
        end
        else
        begin
            if (cfg_wr_en)
                centered_mode <= cfg_wr_data;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_bearings.size() == 0)
                begin
                    $display("%0t: unexpected result: deg %0d coincident %0b",
                             $time, rsp_data.bearing_deg, rsp_data.coincident);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_bearings.pop_front();
                    checked <= checked + 1;
                    if (rsp_data.bearing_deg !== want.bearing_deg ||
                        rsp_data.coincident !== want.coincident)
                    begin
                        $display("%0t: mismatch: expected deg %0d coincident %0b, got deg %0d coincident %0b",
                                 $time, want.bearing_deg, want.coincident,
                                 rsp_data.bearing_deg, rsp_data.coincident);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_bearings.push_back(bearing_of(req_data, centered_mode));
            outstanding <= expected_bearings.size();
        end
    end

endmodule

// ===== tb/compass_bearing_2d_core_tb.sv =====
// ----------------------------------------------------------------------------
// compass_bearing_2d_core_tb: testbench for the compass bearing core
// Drives directed and random observer/object pairs in both range modes with
// bursty requests and a patterned result stall; the checker beside the core
// predicts every bearing and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module compass_bearing_2d_core_tb;
    import cbd_pkg::*;

    localparam int CORDIC_STAGES = 20;
    localparam int LATENCY       = CORDIC_STAGES + 5;
    localparam int LIMIT         = 200_000;
    localparam int COORD_MIN     = -8388608;
    localparam int COORD_MAX     = 8388607;
    localparam int RANDOM_PHASE  = 207;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

    logic     clk;
    logic     rst_n;
    logic     cfg_wr_en;
    logic     cfg_wr_data;
    logic     req_valid;
    logic     req_stall;
    cbd_req_t req_data;
    logic     rsp_valid;
    logic     rsp_stall;
    cbd_rsp_t rsp_data;

    int mismatches;
    int outstanding;
    int checked;
    int cycle_count;
    int requests_sent;
    int mode_writes;
    int burst_left;

    compass_bearing_2d_core #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

    compass_bearing_2d_checker #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .mismatches (mismatches),
        .outstanding(outstanding),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("compass_bearing_2d_core_tb failed");
        $finish;
    end

    // result stall: switch to a randomly chosen style after each random span
    initial
    begin
        stall_style_t style;
        int           span;
        int           period;
        rsp_stall = 1'b0;
        forever
        begin
            style  = stall_style_t'($urandom_range(0, 3));
            span   = $urandom_range(64, 256);
            period = $urandom_range(2, 8);
            for (int k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (style)
                    STALL_NONE:     rsp_stall <= 1'b0;
                    STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: rsp_stall <= ((k % period) < (period / 2));
                    default:        rsp_stall <= 1'b0;
                endcase
            end
        end
    end

    function automatic cbd_req_t make_req(int ox, int oy, int bx, int by);
        cbd_req_t r;
        r.observer_x = ox[COORD_W-1:0];
        r.observer_y = oy[COORD_W-1:0];
        r.object_x   = bx[COORD_W-1:0];
        r.object_y   = by[COORD_W-1:0];
        return r;
    endfunction

    function automatic int rand_coord();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        return int'(v);
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return rand_coord();
        endcase
    endfunction

    // offset a coordinate, flipping the offset if it would leave the range
    function automatic int offset_coord(int base, int off);
        int t;
        t = base + off;
        if (t > COORD_MAX || t < COORD_MIN)
            t = base - off;
        return t;
    endfunction

    function automatic cbd_req_t next_position_pair();
        int ox;
        int oy;
        int k;
        int pick;
        ox   = rand_coord();
        oy   = rand_coord();
        pick = $urandom_range(0, 19);
        k    = $urandom_range(1, 1 << 22);
        if ($urandom_range(0, 1) == 1)
            k = -k;
        if (pick < 10)
            return make_req(ox, oy, rand_coord(), rand_coord());
        else if (pick < 14)
            return make_req(ox, oy,
                            offset_coord(ox, int'($urandom_range(0, 32)) - 16),
                            offset_coord(oy, int'($urandom_range(0, 32)) - 16));
        else if (pick < 16)
        begin
            // axes and diagonals
            case ($urandom_range(0, 3))
                0:       return make_req(ox, oy, ox, offset_coord(oy, k));
                1:       return make_req(ox, oy, offset_coord(ox, k), oy);
                2:       return make_req(ox, oy, offset_coord(ox, k), offset_coord(oy, k));
                default: return make_req(ox, oy, offset_coord(ox, k), offset_coord(oy, -k));
            endcase
        end
        else if (pick == 16)
            return make_req(ox, oy, ox, oy);
        else
            return make_req(edge_coord(), edge_coord(), edge_coord(), edge_coord());
    endfunction

    task automatic send_request(input cbd_req_t r);
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (req_stall);
        requests_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic set_range_mode(input logic centered);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= centered;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mode_writes++;
    endtask

    task automatic send_directed();
        // coincident points, at the origin and at the corner
        send_request(make_req(0, 0, 0, 0));
        send_request(make_req(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        // exact axes: north, south, east, west
        send_request(make_req(0, 0, 0, 100));
        send_request(make_req(0, 0, 0, -100));
        send_request(make_req(0, 0, 100, 0));
        send_request(make_req(0, 0, -100, 0));
        // exact diagonals
        send_request(make_req(-1, -1, 0, 0));
        send_request(make_req(0, 0, -100, -100));
        send_request(make_req(0, 0, 1, -1));
        // largest differences
        send_request(make_req(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        send_request(make_req(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
        send_request(make_req(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        // just either side of due south
        send_request(make_req(0, COORD_MAX, -1, COORD_MIN));
        send_request(make_req(0, COORD_MAX, 1, COORD_MIN));
    endtask

    task automatic send_random(input int count);
        int gap;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 15) == 0)
                    gap = $urandom_range(20, 40);
                else if ($urandom_range(0, 2) == 0)
                    gap = 0;
                else
                    gap = $urandom_range(1, 8);
                if (gap > 0)
                begin
                    @(negedge clk);
                    req_valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            send_request(next_position_pair());
            burst_left--;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        req_valid     = 1'b0;
        req_data      = '0;
        requests_sent = 0;
        mode_writes   = 0;
        burst_left    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_range_mode(1'b0);
        send_directed();
        set_range_mode(1'b1);
        send_directed();

        set_range_mode(1'b1);
        send_random(RANDOM_PHASE);
        set_range_mode(1'b0);
        send_random(RANDOM_PHASE);
        // hold off until the pipeline is empty, then resume
        drain_results();
        send_random(RANDOM_PHASE);
        set_range_mode(1'b1);
        send_random(RANDOM_PHASE);

        drain_results();
        repeat (2 * LATENCY) @(posedge clk);
        $display("Sent %0d position pairs over %0d range-mode writes; %0d bearings checked.",
                 requests_sent, mode_writes, checked);
        $display("Covered coincident points, axes, diagonals, extreme coordinates, both modes.");
        if (mismatches == 0)
            $display("compass_bearing_2d_core_tb passed");
        else
            $display("compass_bearing_2d_core_tb failed");
        $finish;
    end

endmodule
